// ===== hw/rtl/arsw_pkg.sv =====
// Shared types and constants for the alternating row-shift warp unit.
package arsw_pkg;

  // Field and register widths
  localparam int PixW     = 8;
  localparam int LineW    = 13;
  localparam int HeightW  = 13;
  localparam int ShiftW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Longest row-end burst is one pixel plus this many copies
  localparam int BurstCap = 15;
  localparam int MagW     = 4;
  localparam int CntW     = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLineWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgShiftAmount = 2'd2;

  // One run of identical output pixels caused by one input pixel
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [CntW-1:0] cnt;
    logic            row_end;
    logic            frame_end;
  } run_t;

endpackage

// ===== hw/rtl/alternating_row_shift_warp_unit.sv =====
// Top level of the alternating row-shift warp unit.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------------
//  in       | in        | in_valid_i / in_ready_o  | pixel_in_i
//  out      | out       | out_valid_o / out_ready_i| pixel_out_o, last_of_run_o,
//           |           |                          | row_end_o, frame_end_o
//  cfg      | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// A pixel is taken every cycle unless the run register is stalled; its first result is offered
// after it passes through a run register and an output register.
// A row end under a left shift plays out up to 16 pixels, one per cycle while out_ready_i is high; the input
// stalls while the output register is busy with such a burst.
// Reset clears counters and valid flags; the delay line is not cleared.
module alternating_row_shift_warp_unit #(
  parameter int MAX_AMP    = 15,
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arsw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arsw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [arsw_pkg::PixW-1:0]      pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [arsw_pkg::PixW-1:0]      pixel_out_o,
  output logic                           last_of_run_o,
  output logic                           row_end_o,
  output logic                           frame_end_o
);
  import arsw_pkg::*;

  logic run_valid;
  logic run_ready;
  run_t run;

  // Request decode and run formation
  arsw_core #(
    .MAX_AMP   (MAX_AMP),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_in_i (pixel_in_i),
    .run_valid_o(run_valid),
    .run_o      (run),
    .run_ready_i(run_ready)
  );

  // Run playout
  arsw_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_valid_i  (run_valid),
    .run_i        (run),
    .run_ready_o  (run_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .last_of_run_o(last_of_run_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ===== hw/rtl/arsw_core.sv =====
// Row/column tracking, shift selection, delay line and run register.
module arsw_core #(
  parameter int MAX_AMP    = 15,
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arsw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arsw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [arsw_pkg::PixW-1:0]      pixel_in_i,
  output logic                           run_valid_o,
  output arsw_pkg::run_t                 run_o,
  input  logic                           run_ready_i
);
  import arsw_pkg::*;

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WExtW  = ((ColW > LineW) ? ColW : LineW) + 1;
  localparam int HExtW  = ((RowW > HeightW) ? RowW : HeightW) + 1;
  localparam int AmpCap = (MAX_AMP < BurstCap) ? MAX_AMP : BurstCap;
  localparam int TapW   = (AmpCap > 1) ? $clog2(AmpCap) : 1;

  // Configuration registers
  logic [LineW-1:0]   line_width_q;
  logic [HeightW-1:0] frame_height_q;
  logic [ShiftW-1:0]  shift_amount_q;

  // Stream state
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] first_q;
  logic [PixW-1:0] dly_q [AmpCap];

  // Run register
  logic run_valid_q;
  run_t run_q, run_d;

  logic             acc;
  logic [WExtW-1:0] lw_ext, wm1;
  logic [HExtW-1:0] fh_ext, hm1;
  logic             last, row_last;
  logic [CntW-1:0]  mag_raw, mag_a;
  logic [MagW-1:0]  mag, tap_sel;
  logic [TapW-1:0]  tap_idx;
  logic             neg;
  logic             col_ge_mag;
  logic [CntW-1:0]  pos_cnt;
  logic [PixW-1:0]  neg_pix;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !run_valid_q || run_ready_i;
  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

  // Effective width-1 and height-1, zero read as one, clipped to the maxima
  assign lw_ext = WExtW'(line_width_q);
  assign fh_ext = HExtW'(frame_height_q);

  always_comb begin
    if (lw_ext == '0) begin
      wm1 = '0;
    end else if (lw_ext > WExtW'(MAX_WIDTH)) begin
      wm1 = WExtW'(MAX_WIDTH - 1);
    end else begin
      wm1 = lw_ext - WExtW'(1);
    end
    if (fh_ext == '0) begin
      hm1 = '0;
    end else if (fh_ext > HExtW'(MAX_HEIGHT)) begin
      hm1 = HExtW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = fh_ext - HExtW'(1);
    end
  end

  assign last     = WExtW'(col_q) >= wm1;
  assign row_last = HExtW'(row_q) >= hm1;

  // Shift magnitude, saturated to the amp cap and to width-1
  assign mag_raw = shift_amount_q[ShiftW-1] ? (~shift_amount_q + CntW'(1)) : shift_amount_q;
  assign mag_a   = (mag_raw > CntW'(AmpCap)) ? CntW'(AmpCap) : mag_raw;

  always_comb begin
    if (WExtW'(mag_a) > wm1) begin
      mag = wm1[MagW-1:0];
    end else begin
      mag = mag_a[MagW-1:0];
    end
  end

  // Direction flips on odd rows; zero shift counts as positive
  assign neg = (shift_amount_q[ShiftW-1] ^ row_q[0]) && (mag != '0);

  assign tap_sel = mag - MagW'(1);
  assign tap_idx = tap_sel[TapW-1:0];

  assign col_ge_mag = WExtW'(col_q) >= WExtW'(mag);

  // Right shift: row's first pixel near the left edge, else delayed pixel
  always_comb begin
    if (col_q == '0) begin
      neg_pix = pixel_in_i;
    end else if (!col_ge_mag) begin
      neg_pix = first_q;
    end else begin
      neg_pix = dly_q[tap_idx];
    end
  end

  // Left shift: drop the first mag pixels, pad the row end with copies
  assign pos_cnt = CntW'(col_ge_mag) + (last ? CntW'(mag) : CntW'(0));

  always_comb begin
    run_d.pix       = neg ? neg_pix : pixel_in_i;
    run_d.cnt       = neg ? CntW'(1) : pos_cnt;
    run_d.row_end   = last;
    run_d.frame_end = last && row_last;
  end

  // Position counters
  always_comb begin
    if (last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
      row_d = row_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineW'(640);
      frame_height_q <= HeightW'(480);
      shift_amount_q <= ShiftW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLineWidth:   line_width_q   <= cfg_data_i[LineW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_data_i[HeightW-1:0];
        CfgShiftAmount: shift_amount_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      first_q     <= '0;
      run_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        col_q       <= col_d;
        row_q       <= row_d;
        run_valid_q <= 1'b1;
        if (col_q == '0) begin
          first_q <= pixel_in_i;
        end
      end else if (run_ready_i) begin
        run_valid_q <= 1'b0;
      end
    end
  end

  // Run payload and delay line, newest pixel at tap zero
  always_ff @(posedge clk_i) begin
    if (acc) begin
      run_q    <= run_d;
      dly_q[0] <= pixel_in_i;
      for (int k = 1; k < AmpCap; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

endmodule

// ===== hw/rtl/arsw_burst.sv =====
// Output register that plays out each run one pixel per handshake.
module arsw_burst (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      run_valid_i,
  input  arsw_pkg::run_t            run_i,
  output logic                      run_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [arsw_pkg::PixW-1:0] pixel_out_o,
  output logic                      last_of_run_o,
  output logic                      row_end_o,
  output logic                      frame_end_o
);
  import arsw_pkg::*;

  logic [CntW-1:0] rem_q;
  logic [PixW-1:0] pix_q;
  logic            row_end_q;
  logic            frame_end_q;
  logic            is_last;
  logic            out_hs;

  assign out_valid_o   = rem_q != '0;
  assign is_last       = rem_q == CntW'(1);
  assign out_hs        = out_valid_o && out_ready_i;
  assign run_ready_o   = (rem_q == '0) || (is_last && out_ready_i);
  assign pixel_out_o   = pix_q;
  assign last_of_run_o = is_last;
  assign row_end_o     = row_end_q && is_last;
  assign frame_end_o   = frame_end_q && is_last;

  // Remaining count; an empty run just passes through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (run_valid_i && run_ready_o) begin
      rem_q <= run_i.cnt;
    end else if (out_hs) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  // Run payload
  always_ff @(posedge clk_i) begin
    if (run_valid_i && run_ready_o) begin
      pix_q       <= run_i.pix;
      row_end_q   <= run_i.row_end;
      frame_end_q <= run_i.frame_end;
    end
  end

  // Run length never beyond one pixel plus a full burst
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(BurstCap + 1))
    else $error("run length out of range");

  // A run with more than one pixel left holds its count while the output is stalled
  a_rem_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q > CntW'(1)) && !out_ready_i |=> rem_q == $past(rem_q))
    else $error("run counter moved without a handshake");

  // Frame end only on a row end, row end only on a run's last pixel
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  a_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_end_o |-> last_of_run_o && out_valid_o)
    else $error("row end off the last pixel of a run");

endmodule
